[hdl/abl_pkg.sv]
`default_nettype none

package abl_pkg;

  // Table geometry
  localparam int SLOTS      = 128;
  localparam int SLOT_BITS  = $clog2(SLOTS);
  localparam int VALUE_BITS = 32;

  // Free-slot scan: one chunk of used bits per cycle
  localparam int SCAN_WIDTH = (SLOTS < 8) ? SLOTS : 8;
  localparam int CHUNKS     = SLOTS / SCAN_WIDTH;
  localparam int CHUNK_BITS = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CHANGE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WALK_TAIL,
    S_LINK_NEW,
    S_LINK_AFTER,
    S_WALK_PRED,
    S_UNLINK
  } state_t;

  // Command and result payloads
  typedef struct packed {
    opcode_t                opcode;
    logic [6:0]             slot;
    logic signed [31:0]     value;
  } cmd_t;

  typedef struct packed {
    status_t    status;
    logic [6:0] new_slot;
    logic [6:0] count;
  } result_t;

  // Scanner answer
  typedef struct packed {
    logic                 found;
    logic [SLOT_BITS-1:0] slot;
  } scan_t;

endpackage

`default_nettype wire

[hdl/abl_free_scan.sv]
`default_nettype none

// Lowest clear used bit within one chunk of the slot table
module abl_free_scan (
  input  wire logic [abl_pkg::SLOTS-1:0]      used,
  input  wire logic [abl_pkg::CHUNK_BITS-1:0] chunk,
  output abl_pkg::scan_t                      hit
);

  logic [abl_pkg::SCAN_WIDTH-1:0] word;

  assign word = used[chunk * abl_pkg::SCAN_WIDTH +: abl_pkg::SCAN_WIDTH];

  // Priority encode: walk from the top so the lowest free bit wins
  always_comb begin
    hit.found = 1'b0;
    hit.slot  = '0;
    for (int i = abl_pkg::SCAN_WIDTH - 1; i >= 0; i--) begin
      if (!word[i]) begin
        hit.found = 1'b1;
        hit.slot  = abl_pkg::SLOT_BITS'(chunk * abl_pkg::SCAN_WIDTH)
                    | abl_pkg::SLOT_BITS'(i);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/array_backed_linked_list.sv]
// Channel   Ports                   Transfer
// command   start, busy, cmd        start && !busy at a rising edge
// result    done, result            done high for one cycle, always taken
//
// Checks that fail (bad slot) answer in the cycle after the command; change
// answers the same way. Append and insert scan the used bits 8 slots a
// cycle, then append walks the link memory one node a cycle to the tail,
// then S_LINK_NEW and S_LINK_AFTER write the links. Remove walks to the
// predecessor and then unlinks in S_UNLINK.
// Synchronous reset empties the list at once; no clearing pass is needed.
// busy is high while an item is at work; the receiver cannot stall.
`default_nettype none

module array_backed_linked_list (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire abl_pkg::cmd_t   cmd,
  output logic                 done,
  output abl_pkg::result_t     result
);

  localparam int SB = abl_pkg::SLOT_BITS;

  abl_pkg::state_t state, state_next;

  logic [SB-1:0]                    cur, cur_next;
  logic [SB-1:0]                    pred, pred_next;
  logic [SB-1:0]                    fresh, fresh_next;
  logic [SB-1:0]                    tgt, tgt_next;
  logic [abl_pkg::VALUE_BITS-1:0]   val, val_next;
  logic [abl_pkg::CHUNK_BITS-1:0]   scan_chunk, scan_chunk_next;
  abl_pkg::opcode_t                 op, op_next;
  logic [6:0]                       count, count_next;
  logic [SB-1:0]                    head_link, head_link_next;
  logic [abl_pkg::SLOTS-1:0]        used;

  // Memories: links of slots 1.. (head link lives in a register) and values
  logic [SB-1:0]                    link_mem [abl_pkg::SLOTS];
  logic [abl_pkg::VALUE_BITS-1:0]   value_mem [abl_pkg::SLOTS];
  logic [SB-1:0]                    rd_data;
  logic [SB-1:0]                    link_cur;

  logic                             link_we;
  logic [SB-1:0]                    link_wa, link_wd;
  logic                             val_we;
  logic [SB-1:0]                    val_wa;
  logic [abl_pkg::VALUE_BITS-1:0]   val_wd;
  logic                             used_set, used_clr;
  logic [SB-1:0]                    used_idx;

  logic                             fin;
  abl_pkg::status_t                 fin_status;
  logic [SB-1:0]                    fin_slot;

  abl_pkg::scan_t                   scan;

  abl_free_scan u_scan (
    .used  (used),
    .chunk (scan_chunk),
    .hit   (scan)
  );

  assign busy     = (state != abl_pkg::S_IDLE);
  assign link_cur = (cur == '0) ? head_link : rd_data;

  // Link memory: one write port, read of the node the walk sits on next
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    rd_data <= link_mem[cur_next];
  end

  // Value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_wa] <= val_wd;
    end
  end

  // Control and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= abl_pkg::S_IDLE;
      count     <= '0;
      head_link <= '0;
      used      <= {{(abl_pkg::SLOTS-1){1'b0}}, 1'b1};
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      head_link <= head_link_next;
      done      <= fin;
      if (used_set) begin
        used[used_idx] <= 1'b1;
      end else if (used_clr) begin
        used[used_idx] <= 1'b0;
      end
    end
  end

  // Working registers and result
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    pred       <= pred_next;
    fresh      <= fresh_next;
    tgt        <= tgt_next;
    val        <= val_next;
    scan_chunk <= scan_chunk_next;
    op         <= op_next;
    if (fin) begin
      result.status   <= fin_status;
      result.new_slot <= 7'(fin_slot);
      result.count    <= count_next;
    end
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    cur_next        = cur;
    pred_next       = pred;
    fresh_next      = fresh;
    tgt_next        = tgt;
    val_next        = val;
    scan_chunk_next = scan_chunk;
    op_next         = op;
    count_next      = count;
    head_link_next  = head_link;
    link_we         = 1'b0;
    link_wa         = fresh;
    link_wd         = link_cur;
    val_we          = 1'b0;
    val_wa          = fresh;
    val_wd          = val;
    used_set        = 1'b0;
    used_clr        = 1'b0;
    used_idx        = fresh;
    fin             = 1'b0;
    fin_status      = abl_pkg::ST_OK;
    fin_slot        = '0;

    case (state)
      abl_pkg::S_IDLE: begin
        if (start) begin
          op_next         = cmd.opcode;
          tgt_next        = SB'(cmd.slot);
          val_next        = cmd.value[abl_pkg::VALUE_BITS-1:0];
          scan_chunk_next = '0;
          case (cmd.opcode)
            abl_pkg::OP_APPEND: begin
              cur_next   = '0;
              state_next = abl_pkg::S_SCAN;
            end
            abl_pkg::OP_INSERT: begin
              if (!used[SB'(cmd.slot)]) begin
                fin        = 1'b1;
                fin_status = abl_pkg::ST_ILLEGAL;
              end else begin
                cur_next   = SB'(cmd.slot);
                state_next = abl_pkg::S_SCAN;
              end
            end
            abl_pkg::OP_REMOVE: begin
              if (cmd.slot == '0 || !used[SB'(cmd.slot)]) begin
                fin        = 1'b1;
                fin_status = abl_pkg::ST_ILLEGAL;
              end else begin
                cur_next   = '0;
                state_next = abl_pkg::S_WALK_PRED;
              end
            end
            default: begin
              // change value
              fin = 1'b1;
              if (cmd.slot == '0 || !used[SB'(cmd.slot)]) begin
                fin_status = abl_pkg::ST_ILLEGAL;
              end else begin
                val_we = 1'b1;
                val_wa = SB'(cmd.slot);
                val_wd = cmd.value[abl_pkg::VALUE_BITS-1:0];
              end
            end
          endcase
        end
      end

      // Look for the lowest free slot, one chunk a cycle
      abl_pkg::S_SCAN: begin
        if (scan.found) begin
          fresh_next = scan.slot;
          state_next = (op == abl_pkg::OP_APPEND) ? abl_pkg::S_WALK_TAIL
                                                  : abl_pkg::S_LINK_NEW;
        end else if (scan_chunk == abl_pkg::CHUNK_BITS'(abl_pkg::CHUNKS - 1)) begin
          fin        = 1'b1;
          fin_status = abl_pkg::ST_FULL;
          state_next = abl_pkg::S_IDLE;
        end else begin
          scan_chunk_next = scan_chunk + 1'b1;
        end
      end

      // Follow links until the end marker
      abl_pkg::S_WALK_TAIL: begin
        if (link_cur == '0) begin
          state_next = abl_pkg::S_LINK_NEW;
        end else begin
          cur_next = link_cur;
        end
      end

      // New node takes over the successor of the node it follows
      abl_pkg::S_LINK_NEW: begin
        link_we    = 1'b1;
        link_wa    = fresh;
        link_wd    = link_cur;
        val_we     = 1'b1;
        used_set   = 1'b1;
        state_next = abl_pkg::S_LINK_AFTER;
      end

      abl_pkg::S_LINK_AFTER: begin
        if (cur == '0) begin
          head_link_next = fresh;
        end else begin
          link_we = 1'b1;
          link_wa = cur;
          link_wd = fresh;
        end
        count_next = count + 1'b1;
        fin        = 1'b1;
        fin_slot   = fresh;
        state_next = abl_pkg::S_IDLE;
      end

      // Find the node whose link names the target
      abl_pkg::S_WALK_PRED: begin
        if (link_cur == tgt || link_cur == '0) begin
          pred_next  = cur;
          cur_next   = tgt;
          state_next = abl_pkg::S_UNLINK;
        end else begin
          cur_next = link_cur;
        end
      end

      // link_cur now holds the target's successor
      abl_pkg::S_UNLINK: begin
        if (pred == '0) begin
          head_link_next = link_cur;
        end else begin
          link_we = 1'b1;
          link_wa = pred;
          link_wd = link_cur;
        end
        used_clr   = 1'b1;
        used_idx   = tgt;
        count_next = (count != '0) ? count - 1'b1 : count;
        fin        = 1'b1;
        state_next = abl_pkg::S_IDLE;
      end

      default: begin
        state_next = abl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/abl_checker.sv]
`default_nettype none

module abl_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done,
  input wire abl_pkg::result_t result
);

  // Nothing is reported in the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // An accepted command either starts work or answers at once
  a_accept_reacts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  // The end of a busy stretch always delivers a result
  a_busy_end_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  // Failed steps never report a new slot
  a_err_no_slot: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != abl_pkg::ST_OK) |-> (result.new_slot == '0))
    else $error("error result carries a new slot");

  // After a busy stretch, busy is low when its result is strobed
  a_no_start_busy_done: assert property (@(posedge clk) disable iff (rst)
    (done && $past(busy)) |-> !busy || $past(start && !busy))
    else $error("busy continues past a result without a new transfer");

endmodule

bind array_backed_linked_list abl_checker u_abl_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

[verif/array_backed_linked_list_test.sv]
`timescale 1ns / 100ps

module array_backed_linked_list_test;
  import abl_pkg::*;

  localparam int RANDOM_ITEMS   = 1500;
  localparam int DRAIN_CYCLES   = 200;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int MAX_PRINTED    = 100;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  array_backed_linked_list dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // Shadow of the slot table. Values never reach the result port, so only
  // links, used bits and the node count are mirrored.
  logic [6:0] next_of [SLOTS];
  bit         in_list [SLOTS];
  int         list_len;

  cmd_t    cmd_q [$];       // commands waiting for the driver
  result_t expected_q [$];  // predicted results, oldest first
  result_t oldest;
  int      errors   = 0;
  int      gap_left = 0;
  bit      no_idle  = 1'b0;
  longint  cycles   = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Apply one command to the shadow list and queue the result it must give
  task automatic apply_list_op(input cmd_t c);
    result_t r;
    int      fresh;
    int      cur;
    int      steps;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_APPEND, OP_INSERT: begin
        if (c.opcode == OP_INSERT && !in_list[c.slot]) begin
          r.status = ST_ILLEGAL;
        end else begin
          // lowest free slot, 0 when the table is full
          fresh = 0;
          for (int k = SLOTS - 1; k >= 1; k--)
            if (!in_list[k]) fresh = k;
          if (fresh == 0) begin
            r.status = ST_FULL;
          end else begin
            cur = c.slot;
            if (c.opcode == OP_APPEND) begin
              cur = 0;
              for (steps = 0; steps < SLOTS && next_of[cur] != 0; steps++)
                cur = next_of[cur];
            end
            next_of[fresh] = next_of[cur];
            in_list[fresh] = 1'b1;
            next_of[cur]   = 7'(fresh);
            list_len++;
            r.new_slot = 7'(fresh);
          end
        end
      end
      OP_REMOVE: begin
        if (c.slot == 0 || !in_list[c.slot]) begin
          r.status = ST_ILLEGAL;
        end else begin
          // walk to the predecessor, then unlink
          cur = 0;
          for (steps = 0; steps < SLOTS && next_of[cur] != c.slot && next_of[cur] != 0;
               steps++)
            cur = next_of[cur];
          next_of[cur]    = next_of[c.slot];
          in_list[c.slot] = 1'b0;
          next_of[c.slot] = '0;
          if (list_len > 0) list_len--;
        end
      end
      OP_CHANGE: begin
        if (c.slot == 0 || !in_list[c.slot]) r.status = ST_ILLEGAL;
      end
    endcase
    r.count = 7'(list_len);
    expected_q.push_back(r);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 200);
  endfunction

  // A slot that is in use now if there is one, the head only when allowed; else a random slot
  function automatic logic [6:0] pick_live(input bit allow_head);
    int base;
    int idx;
    base = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (base + k) % SLOTS;
      if (in_list[idx] && (idx != 0 || allow_head)) return 7'(idx);
    end
    return 7'(base);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_cmd(input opcode_t op, input logic [6:0] s,
                                    input logic [31:0] v);
    cmd_t c;
    c.opcode = op;
    c.slot   = s;
    c.value  = v;
    cmd_q.push_back(c);
  endfunction

  // Driver: predict on each transfer, then present the next command or idle
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy) apply_list_op(cmd);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start    <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (cmd_q.size() > 0) begin
          cmd      <= cmd_q.pop_front();
          start    <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        report_error($sformatf("unexpected result status=%0d new_slot=%0d count=%0d",
                               result.status, result.new_slot, result.count));
      end else begin
        oldest = expected_q.pop_front();
        if (result.status !== oldest.status)
          report_error($sformatf("status %0d, expected %0d", result.status, oldest.status));
        if (result.new_slot !== oldest.new_slot)
          report_error($sformatf("new_slot %0d, expected %0d",
                                 result.new_slot, oldest.new_slot));
        if (result.count !== oldest.count)
          report_error($sformatf("count %0d, expected %0d", result.count, oldest.count));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == TIMEOUT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    bit         filling;
    int         roll;
    opcode_t    op;
    logic [6:0] s;

    filling = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      next_of[k] = '0;
      in_list[k] = 1'b0;
    end
    in_list[0] = 1'b1;
    list_len   = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: illegal slots on an empty list, including the head
    queue_cmd(OP_CHANGE, 7'd0,   32'd1);
    queue_cmd(OP_REMOVE, 7'd0,   32'd0);
    queue_cmd(OP_INSERT, 7'd5,   32'd7);
    queue_cmd(OP_INSERT, 7'd127, 32'd7);
    queue_cmd(OP_REMOVE, 7'd127, 32'd0);
    queue_cmd(OP_CHANGE, 7'd64,  32'd9);
    // build a list with extreme values; slot is ignored by append
    queue_cmd(OP_APPEND, 7'd127, 32'h7fff_ffff);
    queue_cmd(OP_APPEND, 7'd0,   32'h8000_0000);
    queue_cmd(OP_APPEND, 7'd0,   -32'sd214748364);
    queue_cmd(OP_INSERT, 7'd0,   32'd100);
    queue_cmd(OP_INSERT, 7'd2,   32'd0);
    queue_cmd(OP_INSERT, 7'd3,   32'hffff_ffff);
    queue_cmd(OP_CHANGE, 7'd3,   32'd100);
    // remove tail, first node and a middle node; reuse of the lowest slot
    queue_cmd(OP_REMOVE, 7'd6,   32'd0);
    queue_cmd(OP_REMOVE, 7'd4,   32'd0);
    queue_cmd(OP_REMOVE, 7'd2,   32'd0);
    queue_cmd(OP_APPEND, 7'd0,   32'd42);
    queue_cmd(OP_INSERT, 7'd1,   32'd43);
    queue_cmd(OP_REMOVE, 7'd2,   32'd0);
    queue_cmd(OP_REMOVE, 7'd2,   32'd0);
    queue_cmd(OP_CHANGE, 7'd5,   32'h8000_0000);
    queue_cmd(OP_APPEND, 7'd0,   32'h0000_0001);

    // Random: alternate fill and drain phases so the list runs from empty
    // to a full table and back, with some noise commands mixed in
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      while (cmd_q.size() > 0) @(negedge clk);
      if (filling && list_len >= SLOTS - 1 && $urandom_range(0, 9) == 0)
        filling = 1'b0;
      else if (!filling && list_len == 0)
        filling = 1'b1;
      else if ($urandom_range(0, 199) == 0)
        filling = !filling;
      if ($urandom_range(0, 29) == 0) no_idle = !no_idle;

      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        op = opcode_t'($urandom_range(0, 3));
        s  = 7'($urandom_range(0, SLOTS - 1));
      end else begin
        if (filling)
          op = (roll < 60) ? OP_APPEND : (roll < 80) ? OP_INSERT :
               (roll < 90) ? OP_CHANGE : OP_REMOVE;
        else
          op = (roll < 65) ? OP_REMOVE : (roll < 80) ? OP_CHANGE :
               (roll < 90) ? OP_APPEND : OP_INSERT;
        s = pick_live(op == OP_INSERT);
      end
      queue_cmd(op, s, pick_value());
    end

    // Let every transfer finish, then allow for a late stray result
    while (cmd_q.size() > 0 || start || expected_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
